// ----- design/cfp_pkg.sv -----
// Shared types and constants for the chunk frame parser.
// No dependencies; imported by chunk_frame_parser_core.
package cfp_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam logic [3:0] MIN_FRAME_BYTES = 4'd12;

  typedef enum logic [2:0] {
    PH_IDLEN = 3'd0,
    PH_ID    = 3'd1,
    PH_INDEX = 3'd2,
    PH_DLEN  = 3'd3,
    PH_DATA  = 3'd4,
    PH_TRAIL = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_ID     = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_IGNORE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_BAD_ID_LEN = 3'd2,
    ST_NO_INDEX   = 3'd3,
    ST_NO_DLEN    = 3'd4,
    ST_DATA_TRUNC = 3'd5
  } status_t;

endpackage

// ----- design/chunk_frame_parser_core.sv -----
// Chunk frame parser top level: byte labeling, field decode, frame status.
// Depends on cfp_pkg.
//
// One frame byte enters per item and one result item leaves per byte, in
// the next cycle through a single output register; a new byte is taken every
// cycle while the output side keeps up. Frame layout: 4-byte big-endian id
// length, id bytes, 4-byte big-endian chunk index, 4-byte big-endian data
// length, data bytes. Each byte is tagged header/id/data/ignored on tuser;
// on the last byte tlast is set and tdata carries the chunk index and the
// frame status. Lengths above the LENGTH_BITS counter saturate. The parser
// rearms for a new frame after every last byte.
module chunk_frame_parser_core #(
  parameter int LENGTH_BITS = cfp_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] frame_byte
  input  logic        s_tlast,   // frame_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] out_byte, [10:8] frame_status,
                                 // [42:11] chunk_number, [47:43] zero
  output logic [1:0]  m_tuser,   // [1:0] byte_kind
  output logic        m_tlast    // frame_done
);
  import cfp_pkg::*;

  phase_t                 phase, phase_next, phase_step;
  logic [31:0]            field_shift, field_shift_next, shifted;
  logic [1:0]             field_byte_count, field_byte_count_next;
  logic [LENGTH_BITS-1:0] bytes_remaining, bytes_remaining_next, rem_dec, sat_len;
  logic [3:0]             seen_count, seen_count_next, seen_step;
  logic                   id_length_zero, id_length_zero_next, zero_step;
  logic [31:0]            held_index, held_index_next, index_step;
  logic                   field_done, accept;

  kind_t                  kind;
  status_t                status;
  logic [7:0]             out_byte;
  status_t                out_status;
  logic [31:0]            out_index;
  kind_t                  out_kind;
  logic                   out_last;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign shifted    = {field_shift[23:0], s_tdata};
  assign field_done = (field_byte_count == 2'd3);
  assign rem_dec    = (bytes_remaining != '0) ? bytes_remaining - 1'b1 : bytes_remaining;
  assign sat_len    = ((shifted >> LENGTH_BITS) != 32'd0) ? '1 : LENGTH_BITS'(shifted);
  assign seen_step  = (seen_count < MIN_FRAME_BYTES) ? seen_count + 4'd1 : seen_count;

  // next state
  always_comb begin
    phase_step            = phase;
    field_shift_next      = field_shift;
    field_byte_count_next = field_byte_count;
    bytes_remaining_next  = bytes_remaining;
    id_length_zero_next   = id_length_zero;
    held_index_next       = held_index;
    seen_count_next       = seen_step;
    case (phase)
      PH_IDLEN, PH_INDEX, PH_DLEN: begin
        field_shift_next      = shifted;
        field_byte_count_next = field_done ? 2'd0 : field_byte_count + 2'd1;
        if (field_done) begin
          case (phase)
            PH_IDLEN: begin
              if (shifted == 32'd0) begin
                id_length_zero_next = 1'b1;
                phase_step          = PH_INDEX;
              end else begin
                bytes_remaining_next = sat_len;
                phase_step           = PH_ID;
              end
            end
            PH_INDEX: begin
              held_index_next = shifted;
              phase_step      = PH_DLEN;
            end
            default: begin
              bytes_remaining_next = sat_len;
              phase_step           = (sat_len != '0) ? PH_DATA : PH_TRAIL;
            end
          endcase
        end
      end
      PH_ID, PH_DATA: begin
        bytes_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          phase_step = (phase == PH_ID) ? PH_INDEX : PH_TRAIL;
        end
      end
      default: ;
    endcase
    phase_next = phase_step;
    zero_step  = id_length_zero_next;
    index_step = held_index_next;
    if (s_tlast) begin
      phase_next            = PH_IDLEN;
      field_shift_next      = '0;
      field_byte_count_next = '0;
      bytes_remaining_next  = '0;
      seen_count_next       = '0;
      id_length_zero_next   = 1'b0;
      held_index_next       = '0;
    end
  end

  // result fields
  always_comb begin
    case (phase)
      PH_IDLEN, PH_INDEX, PH_DLEN: kind = KIND_HEADER;
      PH_ID:                       kind = KIND_ID;
      PH_DATA:                     kind = KIND_DATA;
      default:                     kind = KIND_IGNORE;
    endcase
    if (!s_tlast) begin
      status = ST_OK;
    end else if (seen_step < MIN_FRAME_BYTES) begin
      status = ST_TOO_SHORT;
    end else if (zero_step || phase_step inside {PH_IDLEN, PH_ID}) begin
      status = ST_BAD_ID_LEN;
    end else if (phase_step == PH_INDEX) begin
      status = ST_NO_INDEX;
    end else if (phase_step == PH_DLEN) begin
      status = ST_NO_DLEN;
    end else if (phase_step == PH_DATA) begin
      status = ST_DATA_TRUNC;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLEN;
      field_shift      <= '0;
      field_byte_count <= '0;
      bytes_remaining  <= '0;
      seen_count       <= '0;
      id_length_zero   <= 1'b0;
      held_index       <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (accept) begin
        phase            <= phase_next;
        field_shift      <= field_shift_next;
        field_byte_count <= field_byte_count_next;
        bytes_remaining  <= bytes_remaining_next;
        seen_count       <= seen_count_next;
        id_length_zero   <= id_length_zero_next;
        held_index       <= held_index_next;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid         <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte   <= s_tdata;
      out_kind   <= kind;
      out_last   <= s_tlast;
      out_status <= status;
      out_index  <= s_tlast ? index_step : 32'd0;
    end
  end

  assign m_tdata = {5'd0, out_index, out_status, out_byte};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  a_idle_when_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[10:8] == ST_OK && m_tdata[42:11] == 32'd0)
    else $error("status or index set on a byte that is not last");

  a_rearm_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> phase == PH_IDLEN && seen_count == 4'd0)
    else $error("parser not rearmed after last byte");

  a_seen_saturates: assert property (@(posedge clk) disable iff (rst)
    seen_count <= MIN_FRAME_BYTES)
    else $error("byte count above saturation");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

endmodule
